FILE: hdl/ted_pkg.sv
// Shared types and constants for the three-tap echo delay block.
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

    localparam int DLY_BITS = 17;
    localparam int GAIN_BITS = 16;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int FRAC_BITS = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP1_DELAY = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP2_DELAY = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP3_DELAY = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP1_GAIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP2_GAIN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP3_GAIN = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRY_GAIN = 3'd6;

    localparam logic [DLY_BITS-1:0] TAP1_DELAY_RST = 17'd5232;
    localparam logic [DLY_BITS-1:0] TAP2_DELAY_RST = 17'd11184;
    localparam logic [DLY_BITS-1:0] TAP3_DELAY_RST = 17'd17616;
    localparam logic [GAIN_BITS-1:0] TAP1_GAIN_RST = 16'd9830;
    localparam logic [GAIN_BITS-1:0] TAP2_GAIN_RST = 16'd4915;
    localparam logic [GAIN_BITS-1:0] TAP3_GAIN_RST = 16'd3277;
    localparam logic [GAIN_BITS-1:0] DRY_GAIN_RST = 16'd32768;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITE,
        PH_TAP1,
        PH_TAP2,
        PH_TAP3
    } ted_phase_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } ted_tok_t;

endpackage

`default_nettype wire

FILE: hdl/three_tap_echo_delay_top.sv
// Top level of the three-tap echo delay: config, delay memory sequencer, output register.
// m_tvalid rises once the write and three tap reads have passed the operand, product, accumulate and output registers.
// A new sample is taken during the last tap read of the one before, unless the output stalls; the single memory port
// takes one write and three tap reads per sample.
// Reset: synchronous, active low; registers take their defaults, position goes to zero.
// No clearing pass: entries not yet written since reset read as zero via a wrap flag.
`timescale 1ns / 1ps
`default_nettype none

module three_tap_echo_delay_top
    import ted_pkg::*;
#(
    parameter int DELAY_DEPTH = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample_in
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // sample_out
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire [CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AB = $clog2(DELAY_DEPTH);
    localparam int CW = ((AB > DLY_BITS) ? AB : DLY_BITS) + 1;
    localparam logic [CW-1:0] DLY_LIM = CW'(DELAY_DEPTH - 1);
    localparam logic [AB:0] DEPTH_W = (AB + 1)'(DELAY_DEPTH);
    localparam logic [AB-1:0] WP_LAST = AB'(DELAY_DEPTH - 1);

    logic [DLY_BITS-1:0]  tap1_delay_reg, tap2_delay_reg, tap3_delay_reg;
    logic [GAIN_BITS-1:0] tap1_gain_reg, tap2_gain_reg, tap3_gain_reg, dry_gain_reg;

    ted_phase_t           phase_reg, phase_next;
    logic [AB-1:0]        wp_reg;
    logic                 wrapped_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic                 adv;
    logic                 accept;
    logic                 stall;

    logic [DLY_BITS-1:0]  sel_delay;
    logic [GAIN_BITS-1:0] sel_gain;
    logic [CW-1:0]        d_ext, d_clamp;
    logic [AB-1:0]        d_a;
    logic                 wp_ge;
    logic [AB:0]          idx_w;
    logic [AB-1:0]        mem_addr;
    logic                 mem_en;
    logic                 mem_we;

    logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    ted_tok_t             b_tok_reg;
    logic                 b_dry_reg;
    logic                 b_ok_reg;
    logic [GAIN_BITS-1:0] b_gain_reg;
    logic [SAMPLE_BITS-1:0] b_x_reg;
    logic signed [SAMPLE_BITS-1:0] operand;

    logic                 fin_valid;
    logic [SAMPLE_BITS-1:0] fin_sample;
    logic                 out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap1_delay_reg <= TAP1_DELAY_RST;
            tap2_delay_reg <= TAP2_DELAY_RST;
            tap3_delay_reg <= TAP3_DELAY_RST;
            tap1_gain_reg  <= TAP1_GAIN_RST;
            tap2_gain_reg  <= TAP2_GAIN_RST;
            tap3_gain_reg  <= TAP3_GAIN_RST;
            dry_gain_reg   <= DRY_GAIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TAP1_DELAY: tap1_delay_reg <= cfg_data[DLY_BITS-1:0];
                REG_TAP2_DELAY: tap2_delay_reg <= cfg_data[DLY_BITS-1:0];
                REG_TAP3_DELAY: tap3_delay_reg <= cfg_data[DLY_BITS-1:0];
                REG_TAP1_GAIN:  tap1_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_TAP2_GAIN:  tap2_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_TAP3_GAIN:  tap3_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_DRY_GAIN:   dry_gain_reg   <= cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // hold the whole pipeline while a result waits on a full output register
    assign stall = out_valid_reg && !m_tready && fin_valid;
    assign adv = !stall;
    assign s_tready = adv && (phase_reg == PH_IDLE || phase_reg == PH_TAP3);
    assign accept = s_tvalid && s_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (adv) begin
            case (phase_reg)
                PH_IDLE:  phase_next = accept ? PH_WRITE : PH_IDLE;
                PH_WRITE: phase_next = PH_TAP1;
                PH_TAP1:  phase_next = PH_TAP2;
                PH_TAP2:  phase_next = PH_TAP3;
                PH_TAP3:  phase_next = accept ? PH_WRITE : PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // advance the write position after the last tap read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (adv && phase_reg == PH_TAP3) begin
            if (wp_reg == WP_LAST) begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + AB'(1);
            end
        end
    end

    // tap address
    always_comb begin
        case (phase_reg)
            PH_TAP1: begin
                sel_delay = tap1_delay_reg;
                sel_gain  = tap1_gain_reg;
            end
            PH_TAP2: begin
                sel_delay = tap2_delay_reg;
                sel_gain  = tap2_gain_reg;
            end
            PH_TAP3: begin
                sel_delay = tap3_delay_reg;
                sel_gain  = tap3_gain_reg;
            end
            default: begin
                sel_delay = '0;
                sel_gain  = dry_gain_reg;
            end
        endcase
        d_ext   = CW'(sel_delay);
        d_clamp = (d_ext > DLY_LIM) ? DLY_LIM : d_ext;
        d_a     = d_clamp[AB-1:0];
        wp_ge   = (wp_reg >= d_a);
        idx_w   = {1'b0, wp_reg} + (wp_ge ? '0 : DEPTH_W) - {1'b0, d_a};
        mem_addr = (phase_reg == PH_WRITE) ? wp_reg : idx_w[AB-1:0];
        mem_en  = adv && (phase_reg != PH_IDLE);
        mem_we  = (phase_reg == PH_WRITE);
    end

    // single-port delay memory
    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) begin
                mem[mem_addr] <= sample_reg;
            end else begin
                rdata_reg <= mem[mem_addr];
            end
        end
    end

    // operand stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_tok_reg <= '0;
        end else if (adv) begin
            b_tok_reg.valid <= (phase_reg != PH_IDLE);
            b_tok_reg.first <= (phase_reg == PH_WRITE);
            b_tok_reg.last  <= (phase_reg == PH_TAP3);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_dry_reg  <= (phase_reg == PH_WRITE);
            b_ok_reg   <= wrapped_reg || wp_ge;
            b_gain_reg <= sel_gain;
            b_x_reg    <= sample_reg;
        end
    end

    // never-written entries read as zero
    always_comb begin
        if (b_dry_reg) begin
            operand = $signed(b_x_reg);
        end else if (b_ok_reg) begin
            operand = $signed(rdata_reg);
        end else begin
            operand = '0;
        end
    end

    ted_mac #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .tok        (b_tok_reg),
        .operand    (operand),
        .gain       (b_gain_reg),
        .fin_valid  (fin_valid),
        .fin_sample (fin_sample)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && fin_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && fin_valid) begin
            out_data_reg <= fin_sample;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(out_data_reg);

endmodule

`default_nettype wire

FILE: hdl/ted_mac.sv
// Multiply-accumulate of the dry and tap terms, with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module ted_mac
    import ted_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          adv,
    input  wire ted_tok_t                tok,
    input  wire signed [SAMPLE_BITS-1:0] operand,
    input  wire [GAIN_BITS-1:0]          gain,
    output logic                         fin_valid,
    output logic [SAMPLE_BITS-1:0]       fin_sample
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int AW = PW + 2;
    localparam int QW = AW - FRAC_BITS;

    localparam logic signed [QW-1:0] MAXV = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] MINV = QW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (FRAC_BITS - 1));

    ted_tok_t                c_tok_reg;
    logic signed [PW-1:0]    c_prod_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [AW-1:0]    acc_next;
    logic                    fin_valid_reg;
    logic signed [AW-1:0]    fin_sum_reg;
    logic signed [AW-1:0]    rnd;
    logic signed [QW-1:0]    q;

    // stage C: product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_tok_reg <= '0;
        end else if (adv) begin
            c_tok_reg <= tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_prod_reg <= PW'(operand) * PW'($signed({1'b0, gain}));
        end
    end

    // accumulate
    always_comb begin
        acc_next = (c_tok_reg.first ? AW'(0) : acc_reg) + AW'(c_prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (adv) begin
            fin_valid_reg <= c_tok_reg.valid && c_tok_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && c_tok_reg.valid) begin
            acc_reg <= acc_next;
            if (c_tok_reg.last) begin
                fin_sum_reg <= acc_next;
            end
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd = fin_sum_reg + HALF;
        q = QW'(rnd >>> FRAC_BITS);
        if (q > MAXV) begin
            fin_sample = MAXV[SAMPLE_BITS-1:0];
        end else if (q < MINV) begin
            fin_sample = MINV[SAMPLE_BITS-1:0];
        end else begin
            fin_sample = q[SAMPLE_BITS-1:0];
        end
    end

    assign fin_valid = fin_valid_reg;

endmodule

`default_nettype wire
